// ----- rtl/btsp_pkg.sv -----
// Shared types and constants for the BER-TLV stream parser.
package btsp_pkg;

    typedef enum logic [2:0] {
        PH_TAG1  = 3'd0,
        PH_TAG2  = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LENX  = 3'd3,
        PH_VALUE = 3'd4
    } phase_t;

    localparam logic [1:0] KIND_VALUE    = 2'd0;
    localparam logic [1:0] KIND_ELEMENT  = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TRUNCATED  = 2'd1;
    localparam logic [1:0] ST_BAD_TAG    = 2'd2;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd3;

    localparam logic [4:0] TAG_MULTI     = 5'h1F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value_byte;
        logic [15:0] tag;
        logic [15:0] length;
        logic [16:0] elem_bytes;
        logic [1:0]  status;
        logic        last;
    } out_item_t;

endpackage

// ----- rtl/ber_tlv_stream_parser_top.sv -----
// BER-TLV stream parser: byte-wide parse state and a small result queue.
//
// Takes one buffer byte per item and parses back-to-back BER-TLV elements
// (one- or two-byte tags, short or 0x81/0x82 long-form lengths). Each value
// byte comes out as a value result, each finished element as a record with
// tag, length and total size, and errors (truncated buffer, bad tag, bad
// length) as an error result; after an error, bytes up to the end of the
// buffer are dropped. Each byte is parsed in the cycle it is accepted, so an
// item is taken every cycle unless the input stalls. One byte can give up to
// two results; they go into a four-entry result queue that drains one result
// per cycle while res_stall is low, and the input stalls while the queue holds
// more than two results. Sustained rate is one byte per cycle as long as the
// output side keeps up; when bytes yield two, the output drain sets the rate.
module ber_tlv_stream_parser_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  btsp_pkg::in_item_t  src_item,
    output logic                res_valid,
    input  logic                res_stall,
    output btsp_pkg::out_item_t res_item
);
    import btsp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // parse state
    phase_t       phase_reg, phase_next;
    logic [15:0]  tag_reg, tag_next;
    logic [1:0]   lbl_reg, lbl_next;
    logic [15:0]  acc_reg, acc_next;
    logic [15:0]  vleft_reg, vleft_next;
    logic [16:0]  size_reg, size_next;
    logic         skip_reg, skip_next;

    // per-byte decode
    logic         complete;
    logic [1:0]   err;
    logic         emit_value;
    logic [7:0]   b;
    logic         eob;
    logic [1:0]   lbl_dec;
    logic [15:0]  acc_shift;

    // results of this byte
    out_item_t    r0, r1;
    logic [1:0]   nres;

    // result queue
    out_item_t    q_mem [DEPTH];
    logic [PW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;
    logic          accept;
    logic          pop;

    assign b         = src_item.data_byte;
    assign eob       = src_item.end_of_buffer;
    assign accept    = src_valid && !src_stall;
    assign pop       = res_valid && !res_stall;
    assign src_stall = (count_reg > CW'(DEPTH - 2));
    assign res_valid = (count_reg != '0);
    assign res_item  = q_mem[head_reg];
    assign lbl_dec   = lbl_reg - 2'd1;
    assign acc_shift = {acc_reg[7:0], b};

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        lbl_next   = lbl_reg;
        acc_next   = acc_reg;
        vleft_next = vleft_reg;
        size_next  = size_reg;
        skip_next  = skip_reg;
        complete   = 1'b0;
        err        = ST_OK;
        emit_value = 1'b0;

        if (skip_reg)
        begin
            if (eob)
            begin
                skip_next  = 1'b0;
                phase_next = PH_TAG1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_TAG1:
                begin
                    tag_next   = {8'd0, b};
                    size_next  = 17'd1;
                    phase_next = (b[4:0] == TAG_MULTI) ? PH_TAG2 : PH_LEN1;
                end
                PH_TAG2:
                begin
                    if (b[7])
                    begin
                        err = ST_BAD_TAG;
                    end
                    else
                    begin
                        tag_next   = {tag_reg[7:0], b};
                        size_next  = 17'd2;
                        phase_next = PH_LEN1;
                    end
                end
                PH_LEN1:
                begin
                    size_next = size_reg + 17'd1;
                    if (!b[7])
                    begin
                        acc_next   = {8'd0, b};
                        vleft_next = {8'd0, b};
                        if (b == 8'd0)
                            complete = 1'b1;
                        else
                            phase_next = PH_VALUE;
                    end
                    else if (b[6:0] == 7'd0 || b[6:0] > 7'd2)
                    begin
                        err = ST_BAD_LENGTH;
                    end
                    else
                    begin
                        lbl_next   = b[1:0];
                        acc_next   = 16'd0;
                        phase_next = PH_LENX;
                    end
                end
                PH_LENX:
                begin
                    acc_next  = acc_shift;
                    size_next = size_reg + 17'd1;
                    lbl_next  = lbl_dec;
                    if (lbl_dec == 2'd0)
                    begin
                        vleft_next = acc_shift;
                        if (acc_shift == 16'd0)
                            complete = 1'b1;
                        else
                            phase_next = PH_VALUE;
                    end
                end
                default:
                begin
                    emit_value = 1'b1;
                    size_next  = size_reg + 17'd1;
                    vleft_next = vleft_reg - 16'd1;
                    if (vleft_reg == 16'd1)
                        complete = 1'b1;
                end
            endcase

            if (complete)
                phase_next = PH_TAG1;
            else if (err == ST_OK && eob && phase_next != PH_TAG1)
                err = ST_TRUNCATED;

            if (err != ST_OK)
            begin
                phase_next = PH_TAG1;
                skip_next  = !eob;
            end

            if (eob)
                phase_next = PH_TAG1;
        end
    end

    // results of the accepted byte
    always_comb
    begin
        out_item_t rec;
        out_item_t val;
        out_item_t bad;

        rec            = '0;
        rec.kind       = KIND_ELEMENT;
        rec.tag        = tag_next;
        rec.length     = acc_next;
        rec.elem_bytes = size_next;
        rec.last       = 1'b1;

        val            = '0;
        val.kind       = KIND_VALUE;
        val.value_byte = b;

        bad            = '0;
        bad.kind       = KIND_ERROR;
        bad.status     = err;
        bad.last       = 1'b1;

        r0   = '0;
        r1   = '0;
        nres = 2'd0;

        if (emit_value)
        begin
            r0   = val;
            nres = 2'd1;
            if (complete)
            begin
                r1   = rec;
                nres = 2'd2;
            end
            else if (err != ST_OK)
            begin
                r1   = bad;
                nres = 2'd2;
            end
            else
            begin
                r0.last = 1'b1;
            end
        end
        else if (complete)
        begin
            r0   = rec;
            nres = 2'd1;
        end
        else if (err != ST_OK)
        begin
            r0   = bad;
            nres = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG1;
            tag_reg   <= '0;
            lbl_reg   <= '0;
            acc_reg   <= '0;
            vleft_reg <= '0;
            size_reg  <= '0;
            skip_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            lbl_reg   <= lbl_next;
            acc_reg   <= acc_next;
            vleft_reg <= vleft_next;
            size_reg  <= size_next;
            skip_reg  <= skip_next;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && nres != 2'd0)
        begin
            q_mem[tail_reg] <= r0;
            if (nres == 2'd2)
                q_mem[tail_reg + PW'(1)] <= r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (pop)
                head_reg <= head_reg + PW'(1);
            if (accept)
                tail_reg <= tail_reg + PW'(nres);
            count_reg <= count_reg + (accept ? CW'(nres) : CW'(0)) - CW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue overflow");

    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && skip_reg) |=> (count_reg <= $past(count_reg)))
        else $error("result produced while dropping bytes");

    a_eob_resync: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && src_item.end_of_buffer) |=> (phase_reg == PH_TAG1 && !skip_reg))
        else $error("parser not back at tag start after end of buffer");

    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.kind == KIND_ERROR) |-> (res_item.status != ST_OK && res_item.last))
        else $error("error result without status or last");

endmodule

// ----- sim/ber_tlv_stream_parser_top_test.sv -----
// Self-checking testbench for the BER-TLV stream parser top level.
`timescale 1ns / 1ps

module ber_tlv_stream_parser_top_test;
    import btsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    in_item_t  src_item = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_item_t res_item;

    ber_tlv_stream_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    phase_t      parse_phase = PH_TAG1;
    logic [15:0] tag_hold = '0;
    logic [1:0]  len_bytes_left = '0;
    logic [15:0] len_accum = '0;
    logic [15:0] value_left = '0;
    logic [16:0] elem_size = '0;
    logic        skipping = 1'b0;

    out_item_t   pending_results[$];
    out_item_t   oldest;
    logic [7:0]  frame_bytes[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int parsed_bytes = 0;
    int frames_sent = 0;
    int values_seen = 0;
    int elements_seen = 0;
    int errors_seen = 0;

    function automatic out_item_t make_result(logic [1:0] kind, logic [7:0] vb,
                                              logic [15:0] tg, logic [15:0] len,
                                              logic [16:0] tot, logic [1:0] st);
        out_item_t r;
        r.kind       = kind;
        r.value_byte = vb;
        r.tag        = tg;
        r.length     = len;
        r.elem_bytes = tot;
        r.status     = st;
        r.last       = 1'b0;
        return r;
    endfunction

    // Advance the parser model by one accepted byte and queue what it yields.
    task automatic parse_byte(input in_item_t it);
        out_item_t  res [2];
        int         n;
        logic       complete;
        logic [1:0] err;
        logic [7:0] b;
        logic       eob;
        begin
            b        = it.data_byte;
            eob      = it.end_of_buffer;
            n        = 0;
            complete = 1'b0;
            err      = ST_OK;
            if (skipping) begin
                if (eob) begin
                    skipping    = 1'b0;
                    parse_phase = PH_TAG1;
                end
            end else begin
                parsed_bytes++;
                case (parse_phase)
                    PH_TAG1: begin
                        tag_hold    = {8'h00, b};
                        elem_size   = 17'd1;
                        parse_phase = (b[4:0] == TAG_MULTI) ? PH_TAG2 : PH_LEN1;
                    end
                    PH_TAG2: begin
                        if (b[7]) begin
                            err = ST_BAD_TAG;
                        end else begin
                            tag_hold    = {tag_hold[7:0], b};
                            elem_size   = 17'd2;
                            parse_phase = PH_LEN1;
                        end
                    end
                    PH_LEN1: begin
                        elem_size = elem_size + 17'd1;
                        if (!b[7]) begin
                            len_accum  = {8'h00, b};
                            value_left = {8'h00, b};
                            if (b == 8'h00)
                                complete = 1'b1;
                            else
                                parse_phase = PH_VALUE;
                        end else if (b[6:0] == 7'd0 || b[6:0] > 7'd2) begin
                            err = ST_BAD_LENGTH;
                        end else begin
                            len_bytes_left = b[1:0];
                            len_accum      = '0;
                            parse_phase    = PH_LENX;
                        end
                    end
                    PH_LENX: begin
                        len_accum      = {len_accum[7:0], b};
                        elem_size      = elem_size + 17'd1;
                        len_bytes_left = len_bytes_left - 2'd1;
                        if (len_bytes_left == 2'd0) begin
                            value_left = len_accum;
                            if (value_left == 16'd0)
                                complete = 1'b1;
                            else
                                parse_phase = PH_VALUE;
                        end
                    end
                    default: begin
                        res[n] = make_result(KIND_VALUE, b, '0, '0, '0, ST_OK);
                        n++;
                        elem_size  = elem_size + 17'd1;
                        value_left = value_left - 16'd1;
                        if (value_left == 16'd0)
                            complete = 1'b1;
                    end
                endcase

                if (complete) begin
                    res[n] = make_result(KIND_ELEMENT, 8'h00, tag_hold, len_accum,
                                         elem_size, ST_OK);
                    n++;
                    parse_phase = PH_TAG1;
                end else if (err == ST_OK && eob && parse_phase != PH_TAG1) begin
                    err = ST_TRUNCATED;
                end

                if (err != ST_OK) begin
                    res[n] = make_result(KIND_ERROR, 8'h00, '0, '0, '0, err);
                    n++;
                    parse_phase = PH_TAG1;
                    skipping    = !eob;
                end

                if (eob)
                    parse_phase = PH_TAG1;
                if (n > 0)
                    res[n-1].last = 1'b1;
                for (int i = 0; i < n; i++)
                    pending_results.push_back(res[i]);
            end
        end
    endtask

    function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // receiver back-pressure
    always @(posedge clk)
        res_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // input/output monitor, scoreboard and watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (src_valid && !src_stall)
                parse_byte(src_item);
            if (res_valid && !res_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: kind 0x%0h tag 0x%0h status 0x%0h",
                             $time, res_item.kind, res_item.tag, res_item.status);
                    mismatches++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("kind", 17'(oldest.kind), 17'(res_item.kind));
                    check_field("value_byte", 17'(oldest.value_byte),
                                17'(res_item.value_byte));
                    check_field("tag", 17'(oldest.tag), 17'(res_item.tag));
                    check_field("length", 17'(oldest.length), 17'(res_item.length));
                    check_field("elem_bytes", oldest.elem_bytes, res_item.elem_bytes);
                    check_field("status", 17'(oldest.status), 17'(res_item.status));
                    check_field("last", 17'(oldest.last), 17'(res_item.last));
                    case (oldest.kind)
                        KIND_VALUE:   values_seen++;
                        KIND_ELEMENT: elements_seen++;
                        default:      errors_seen++;
                    endcase
                end
            end
            if ((src_valid && !src_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_results.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        begin
            src_item  <= '{data_byte: b, end_of_buffer: eob};
            src_valid <= 1'b1;
            @(posedge clk);
            while (src_stall)
                @(posedge clk);
            while ($urandom_range(99) < idle_pct) begin
                src_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic send_frame();
        begin
            for (int i = 0; i < frame_bytes.size(); i++)
                send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
            frames_sent++;
        end
    endtask

    task automatic wait_drained();
        begin
            src_valid <= 1'b0;
            @(posedge clk);
            while (pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // Random buffer: mostly well-formed elements, some with a bad tag, a bad
    // length, a cut-off end, or pure noise.
    task automatic build_frame();
        int         n_elem;
        int         fault;
        int         form;
        int         len;
        logic [7:0] t;
        begin
            frame_bytes.delete();
            if ($urandom_range(99) < 5) begin
                repeat ($urandom_range(1, 8))
                    frame_bytes.push_back(8'($urandom));
            end else begin
                n_elem = $urandom_range(1, 4);
                for (int e = 0; e < n_elem; e++) begin
                    fault = ($urandom_range(99) < 8) ? $urandom_range(1, 2) : 0;
                    t = 8'($urandom);
                    if (fault == 1)
                        t[4:0] = TAG_MULTI;
                    frame_bytes.push_back(t);
                    if (t[4:0] == TAG_MULTI)
                        frame_bytes.push_back(fault == 1 ? (8'h80 | 8'($urandom))
                                                         : (8'h7F & 8'($urandom)));
                    if (fault == 2)
                        frame_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h80
                                              : 8'($urandom_range(8'h83, 8'hFF)));
                    if (fault != 0) begin
                        repeat ($urandom_range(0, 3))
                            frame_bytes.push_back(8'($urandom));
                        break;
                    end
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 12);
                    form = $urandom_range(0, 9);
                    if (form < 6) begin
                        frame_bytes.push_back(8'(len & 8'h7F));
                        len = len & 8'h7F;
                    end else if (form < 8) begin
                        frame_bytes.push_back(8'h81);
                        frame_bytes.push_back(8'(len));
                    end else begin
                        frame_bytes.push_back(8'h82);
                        frame_bytes.push_back(8'h00);
                        frame_bytes.push_back(8'(len));
                    end
                    repeat (len)
                        frame_bytes.push_back(8'($urandom));
                end
                if (frame_bytes.size() > 1 && $urandom_range(99) < 12)
                    frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
            end
        end
    endtask

    task automatic test_directed_cases();
        begin
            frame_bytes = '{8'h00, 8'h00};                      // zero tag, empty value
            send_frame();
            frame_bytes = '{8'h5F, 8'h2D, 8'h02, 8'h00, 8'hFF};  // two-byte tag
            send_frame();
            frame_bytes = '{8'h1F, 8'h80, 8'h00};               // bad second tag byte, then skip
            send_frame();
            frame_bytes = '{8'h01, 8'h80};                      // bad length on final byte
            send_frame();
            frame_bytes = '{8'h02, 8'hFF, 8'h9F};               // bad length, then skip
            send_frame();
            frame_bytes = '{8'h4F, 8'h81, 8'h01, 8'hAA};        // 0x81 long form
            send_frame();
            frame_bytes = '{8'hC0, 8'h82, 8'h00, 8'h00};        // 0x82 with zero length
            send_frame();
            frame_bytes = '{8'hFF};                             // ends wanting a second tag byte
            send_frame();
            frame_bytes = '{8'h01, 8'h03, 8'h55};               // ends inside the value
            send_frame();
            frame_bytes = '{8'h42};                             // ends after the tag
            send_frame();
            wait_drained();
        end
    endtask

    task automatic test_long_value();
        begin
            frame_bytes = '{8'h5F, 8'h49, 8'h82, 8'h01, 8'h2C};
            repeat (300)
                frame_bytes.push_back(8'($urandom));
            send_frame();
            wait_drained();
        end
    endtask

    task automatic test_random_buffers(input int idle, input int stall, input int n_items);
        int start;
        begin
            idle_pct  = idle;
            stall_pct = stall;
            start     = parsed_bytes;
            while (parsed_bytes - start < n_items) begin
                build_frame();
                send_frame();
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_buffers(0, 0, 200);
        test_random_buffers(64, 0, 200);
        test_random_buffers(0, 64, 200);
        test_random_buffers(16, 16, 200);
        test_long_value();
        idle_pct  = 0;
        stall_pct = 0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Parsed %0d bytes in %0d buffers under four idle/stall mixes;", parsed_bytes,
                 frames_sent);
        $display("checked %0d value bytes, %0d element records and %0d errors.",
                 values_seen, elements_seen, errors_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/btsp_pkg.sv
rtl/ber_tlv_stream_parser_top.sv
sim/ber_tlv_stream_parser_top_test.sv
